[hw/rtl/chm_pkg.sv]
// Shared types and constants of the color histogram block.
// No dependencies; chm_front, chm_update and the top level refer to it by scoped names.
package chm_pkg;

    // operation codes of an input transfer
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // configuration register indexes
    localparam logic CFG_SAMPLE_STRIDE = 1'b0;
    localparam logic CFG_IGNORE_WHITE  = 1'b1;

    localparam int unsigned CFG_DATA_W = 8;

    // pixel filter thresholds
    localparam logic [7:0] ALPHA_LIMIT = 8'd125;
    localparam logic [7:0] WHITE_LIMIT = 8'd250;

    typedef struct packed {
        logic [7:0] red_low;
        logic [7:0] red_high;
        logic [7:0] green_low;
        logic [7:0] green_high;
        logic [7:0] blue_low;
        logic [7:0] blue_high;
    } t_bounds;

    localparam t_bounds BOUNDS_RESET = '{
        red_low:    8'hFF,
        red_high:   8'h00,
        green_low:  8'hFF,
        green_high: 8'h00,
        blue_low:   8'hFF,
        blue_high:  8'h00
    };

    // per-item control handed from the front stage to the bin update stage
    typedef struct packed {
        logic    accepted;   // pixel counted: increment its bin
        logic    read_op;    // read and clear a bin
        t_bounds bounds;     // bounds after this item
    } t_item_info;

endpackage

[hw/rtl/chm_if.sv]
// Valid/ready channel interfaces for pixel input and result output.
// No dependencies.
interface chm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [14:0] bin_index;

    modport source (output valid, operation, red, green, blue, alpha, bin_index,
                    input ready);
    modport sink   (input valid, operation, red, green, blue, alpha, bin_index,
                    output ready);
endinterface

interface chm_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [31:0] bin_count;
    logic [7:0]  red_low;
    logic [7:0]  red_high;
    logic [7:0]  green_low;
    logic [7:0]  green_high;
    logic [7:0]  blue_low;
    logic [7:0]  blue_high;

    modport source (output valid, accepted, bin_count, red_low, red_high,
                    green_low, green_high, blue_low, blue_high,
                    input ready);
    modport sink   (input valid, accepted, bin_count, red_low, red_high,
                    green_low, green_high, blue_low, blue_high,
                    output ready);
endinterface

[hw/rtl/chm_hist_mem.sv]
// Histogram bin storage: one write port, one read port, registered read data.
// No dependencies.
module chm_hist_mem #(
    parameter int unsigned ADDR_W = 15,
    parameter int unsigned DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // old data on a same-address read and write; the update stage forwards
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/chm_front.sv]
// Front stage: config registers, stride phase, pixel filter, quantizer,
// running bounds and bin address. Uses chm_pkg.
module chm_front #(
    parameter int unsigned CHANNEL_BITS = 5,
    parameter int unsigned ADDR_W       = 3 * CHANNEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_take,
    input  logic [1:0]                      i_operation,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    input  logic [7:0]                      i_alpha,
    input  logic [14:0]                     i_bin_index,
    output logic [ADDR_W-1:0]               o_rd_addr,
    output chm_pkg::t_item_info             o_info
);

    logic [7:0]       r_stride;
    logic             r_ignore_white;
    logic [7:0]       r_phase;
    chm_pkg::t_bounds r_bounds;

    logic [7:0]       n_phase;
    chm_pkg::t_bounds n_bounds;

    logic [CHANNEL_BITS-1:0] q_red, q_green, q_blue;
    logic [7:0] q8_red, q8_green, q8_blue;
    logic [7:0] stride_eff;
    logic [8:0] phase_inc;
    logic       sampled, near_white, keep;

    assign q_red    = i_red[7 -: CHANNEL_BITS];
    assign q_green  = i_green[7 -: CHANNEL_BITS];
    assign q_blue   = i_blue[7 -: CHANNEL_BITS];
    assign q8_red   = 8'(q_red);
    assign q8_green = 8'(q_green);
    assign q8_blue  = 8'(q_blue);

    // stride 0 behaves as 1
    assign stride_eff = (r_stride == 8'd0) ? 8'd1 : r_stride;
    assign phase_inc  = {1'b0, r_phase} + 9'd1;
    assign sampled    = (r_phase == 8'd0);
    assign near_white = r_ignore_white && (i_red > chm_pkg::WHITE_LIMIT)
                        && (i_green > chm_pkg::WHITE_LIMIT)
                        && (i_blue > chm_pkg::WHITE_LIMIT);
    assign keep       = sampled && (i_alpha > chm_pkg::ALPHA_LIMIT) && !near_white;

    always_comb begin
        n_phase  = r_phase;
        n_bounds = r_bounds;
        case (i_operation)
            chm_pkg::OP_PIXEL: begin
                n_phase = (phase_inc >= {1'b0, stride_eff}) ? 8'd0 : phase_inc[7:0];
                if (keep) begin
                    if (q8_red < r_bounds.red_low)     n_bounds.red_low    = q8_red;
                    if (q8_red > r_bounds.red_high)    n_bounds.red_high   = q8_red;
                    if (q8_green < r_bounds.green_low) n_bounds.green_low  = q8_green;
                    if (q8_green > r_bounds.green_high) n_bounds.green_high = q8_green;
                    if (q8_blue < r_bounds.blue_low)   n_bounds.blue_low   = q8_blue;
                    if (q8_blue > r_bounds.blue_high)  n_bounds.blue_high  = q8_blue;
                end
            end
            chm_pkg::OP_START: begin
                n_phase  = 8'd0;
                n_bounds = chm_pkg::BOUNDS_RESET;
            end
            default: ;
        endcase
    end

    assign o_rd_addr = (i_operation == chm_pkg::OP_READ) ? ADDR_W'(i_bin_index)
                                                         : {q_red, q_green, q_blue};

    assign o_info.accepted = (i_operation == chm_pkg::OP_PIXEL) && keep;
    assign o_info.read_op  = (i_operation == chm_pkg::OP_READ);
    assign o_info.bounds   = n_bounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride       <= 8'd1;
            r_ignore_white <= 1'b0;
            r_phase        <= 8'd0;
            r_bounds       <= chm_pkg::BOUNDS_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    chm_pkg::CFG_SAMPLE_STRIDE: r_stride       <= i_cfg_data;
                    chm_pkg::CFG_IGNORE_WHITE:  r_ignore_white <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_take) begin
                r_phase  <= n_phase;
                r_bounds <= n_bounds;
            end
        end
    end

endmodule

[hw/rtl/chm_update.sv]
// Bin update stage: read-modify-write of the histogram with write-back
// forwarding, post-reset clearing sweep, result register. Uses chm_pkg, chm_if.
module chm_update #(
    parameter int unsigned ADDR_W      = 15,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    input  chm_pkg::t_item_info    i_info,
    output logic                   o_in_ready,
    input  logic [COUNT_WIDTH-1:0] i_rd_data,
    output logic                   o_wr_en,
    output logic [ADDR_W-1:0]      o_wr_addr,
    output logic [COUNT_WIDTH-1:0] o_wr_data,
    chm_out_if.source              o_res
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [ADDR_W-1:0]      ADDR_LAST = '1;

    // clearing sweep
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // item waiting for its read data
    logic                r_s1_valid;
    logic [ADDR_W-1:0]   r_s1_addr;
    chm_pkg::t_item_info r_s1_info;

    // last bin write, newer than the memory read when addresses match
    logic                   r_wb_valid;
    logic [ADDR_W-1:0]      r_wb_addr;
    logic [COUNT_WIDTH-1:0] r_wb_data;

    // result register
    logic             r_out_valid;
    logic             r_out_accepted;
    logic [31:0]      r_out_count;
    chm_pkg::t_bounds r_out_bounds;

    logic                   s1_adv, s1_write;
    logic [COUNT_WIDTH-1:0] cur_count, inc_count, s1_wr_data;

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign o_in_ready = !r_clr_busy && (!r_s1_valid || s1_adv);

    assign cur_count  = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : i_rd_data;
    assign inc_count  = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    assign s1_write   = s1_adv && (r_s1_info.accepted || r_s1_info.read_op);
    assign s1_wr_data = r_s1_info.accepted ? inc_count : '0;

    assign o_wr_en   = r_clr_busy || s1_write;
    assign o_wr_addr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign o_wr_data = r_clr_busy ? '0 : s1_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_write) begin
                r_wb_valid <= 1'b1;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_s1_addr <= i_rd_addr;
            r_s1_info <= i_info;
        end
        if (s1_write) begin
            r_wb_addr <= r_s1_addr;
            r_wb_data <= s1_wr_data;
        end
        if (s1_adv) begin
            r_out_accepted <= r_s1_info.accepted;
            r_out_count    <= r_s1_info.read_op ? 32'(cur_count) : 32'd0;
            r_out_bounds   <= r_s1_info.bounds;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.accepted   = r_out_accepted;
    assign o_res.bin_count  = r_out_count;
    assign o_res.red_low    = r_out_bounds.red_low;
    assign o_res.red_high   = r_out_bounds.red_high;
    assign o_res.green_low  = r_out_bounds.green_low;
    assign o_res.green_high = r_out_bounds.green_high;
    assign o_res.blue_low   = r_out_bounds.blue_low;
    assign o_res.blue_high  = r_out_bounds.blue_high;

endmodule

[hw/rtl/color_histogram_with_bounds_top.sv]
// Top level of the color histogram with per-channel bounds.
// Depends on chm_pkg, chm_if, chm_hist_mem, chm_front, chm_update.
//
//  channel   dir   handshake      payload
//  -------   ---   ------------   ----------------------------------------------
//  i_pix     in    valid/ready    operation, red, green, blue, alpha, bin_index
//  o_res     out   valid/ready    accepted, bin_count, red/green/blue low/high
//  i_cfg_*   in    write enable   index 0 sample_stride, index 1 ignore_white
//
// One transfer per cycle sustained while o_res is ready and clearing is done.
// o_res.valid is registered: the bin read launches with the transfer, the item
// waits in the read stage, and as it advances the increment/clear, write-back and
// result register follow, with the last write forwarded to the next item.
// After reset the block clears all 2**(3*CHANNEL_BITS) bins (32768 by default)
// with i_pix.ready low; config writes are taken during that time.
// A stall on o_res holds the update stage; one more input transfer can still be
// taken into the read stage before i_pix.ready drops.
module color_histogram_with_bounds_top #(
    parameter int unsigned CHANNEL_BITS = 5,
    parameter int unsigned COUNT_WIDTH  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_index,
    input  logic [chm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    chm_in_if.sink                         i_pix,
    chm_out_if.source                      o_res
);

    localparam int unsigned ADDR_W = 3 * CHANNEL_BITS;

    logic                   take;
    logic                   in_ready;
    logic [ADDR_W-1:0]      rd_addr;
    chm_pkg::t_item_info    info;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign i_pix.ready = in_ready;
    assign take        = i_pix.valid && in_ready;

    // stride, filter, quantize and bounds happen at the input transfer
    chm_front #(
        .CHANNEL_BITS (CHANNEL_BITS),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_operation (i_pix.operation),
        .i_red       (i_pix.red),
        .i_green     (i_pix.green),
        .i_blue      (i_pix.blue),
        .i_alpha     (i_pix.alpha),
        .i_bin_index (i_pix.bin_index),
        .o_rd_addr   (rd_addr),
        .o_info      (info)
    );

    // bin read is launched in the same cycle as the input transfer
    chm_hist_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (take),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    chm_update #(
        .ADDR_W      (ADDR_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_rd_addr  (rd_addr),
        .i_info     (info),
        .o_in_ready (in_ready),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_res      (o_res)
    );

endmodule
